FILE: sv/xdiv_pkg.sv
// xdiv_pkg: shared types and constants for the x86 divide unit.
// No dependencies.
`timescale 1ns / 1ps
package xdiv_pkg;
  localparam int unsigned NCELL = 32;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_DWORD = 2'd2,
    SZ_DWORD_ALT = 2'd3
  } size_t;

  typedef struct packed {
    logic        vld;
    logic        err;
    logic        qneg;
    logic        rneg;
    logic [1:0]  sz;
    logic        sgn;
    logic [32:0] rem;
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic [31:0] quo;
  } cell_t;
endpackage

FILE: sv/xdiv_cell.sv
// xdiv_cell: one restoring-division stage, produces one quotient bit per item.
// Depends on xdiv_pkg.
`timescale 1ns / 1ps
module xdiv_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  xdiv_pkg::cell_t d_in,
  output xdiv_pkg::cell_t d_out
);
  import xdiv_pkg::*;

  cell_t       d_out_r;
  cell_t       d_out_nxt;
  logic [33:0] shf;
  logic [33:0] dif;

  always_comb begin
    d_out_nxt = d_in;
    shf = {d_in.rem, d_in.dvd[31]};
    dif = shf - {2'b00, d_in.dvs};
    d_out_nxt.dvd = {d_in.dvd[30:0], 1'b0};
    if (!dif[33]) begin
      d_out_nxt.rem = dif[32:0];
      d_out_nxt.quo = {d_in.quo[30:0], 1'b1};
    end else begin
      d_out_nxt.rem = shf[32:0];
      d_out_nxt.quo = {d_in.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_out_r.vld <= 1'b0;
    end else begin
      d_out_r.vld <= d_out_nxt.vld;
    end
    d_out_r.err  <= d_out_nxt.err;
    d_out_r.qneg <= d_out_nxt.qneg;
    d_out_r.rneg <= d_out_nxt.rneg;
    d_out_r.sz   <= d_out_nxt.sz;
    d_out_r.sgn  <= d_out_nxt.sgn;
    d_out_r.rem  <= d_out_nxt.rem;
    d_out_r.dvd  <= d_out_nxt.dvd;
    d_out_r.dvs  <= d_out_nxt.dvs;
    d_out_r.quo  <= d_out_nxt.quo;
  end

  assign d_out = d_out_r;
endmodule

FILE: sv/x86_divide_unit.sv
// x86_divide_unit: top level, operand prep, 32-cell divider row, result fixup.
// Depends on xdiv_pkg and xdiv_cell.
`timescale 1ns / 1ps
// channel | ports                                            | transfer
// in      | start, in_mode, in_size, in_dividend, in_divisor | start && !busy
// out     | out_strobe, out_quotient, out_remainder, ...     | out_strobe
// cfg     | cfg_we, cfg_wdata                                | cfg_we
// One item per cycle; an accepted transfer's result is registered through the prep
// register, the 32 cells and the output register.
// Remainder is seeded with the high dividend half (zero for byte/word).
// busy is always low. Sync active-low reset clears the valid chain and config.
// The receiver cannot stall.
module x86_divide_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [1:0]  in_size,
  input  logic [63:0] in_dividend,
  input  logic [31:0] in_divisor,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_strobe,
  output logic [31:0] out_quotient,
  output logic [31:0] out_remainder,
  output logic        out_divide_error,
  output logic        out_aux_toggle
);
  import xdiv_pkg::*;

  logic aux_r;
  cell_t prep_nxt;
  cell_t prep_r;
  cell_t chain [NCELL+1];

  logic [63:0] dvd_m;
  logic [31:0] dvs_m;
  logic [31:0] hi;
  logic        nd;
  logic        nv;

  assign busy = 1'b0;

  always_comb begin
    dvd_m = '0;
    dvs_m = '0;
    nd = 1'b0;
    nv = 1'b0;
    unique case (size_t'(in_size))
      SZ_BYTE: begin
        nd = in_mode & in_dividend[15];
        nv = in_mode & in_divisor[7];
        dvd_m = {48'd0, nd ? 16'(-in_dividend[15:0]) : in_dividend[15:0]};
        dvs_m = {24'd0, nv ? 8'(-in_divisor[7:0]) : in_divisor[7:0]};
      end
      SZ_WORD: begin
        nd = in_mode & in_dividend[31];
        nv = in_mode & in_divisor[15];
        dvd_m = {32'd0, nd ? 32'(-in_dividend[31:0]) : in_dividend[31:0]};
        dvs_m = {16'd0, nv ? 16'(-in_divisor[15:0]) : in_divisor[15:0]};
      end
      SZ_DWORD, SZ_DWORD_ALT: begin
        nd = in_mode & in_dividend[63];
        nv = in_mode & in_divisor[31];
        dvd_m = nd ? 64'(-in_dividend) : in_dividend;
        dvs_m = nv ? 32'(-in_divisor) : in_divisor;
      end
      default: ;
    endcase
    unique case (size_t'(in_size))
      SZ_BYTE, SZ_WORD: hi = '0;
      SZ_DWORD, SZ_DWORD_ALT: hi = dvd_m[63:32];
    endcase
    prep_nxt.vld  = start & ~busy;
    prep_nxt.sgn  = in_mode;
    prep_nxt.sz   = in_size;
    prep_nxt.qneg = nd ^ nv;
    prep_nxt.rneg = nd;
    // high half at or above divisor: quotient needs more than 32 bits
    prep_nxt.err  = (dvs_m == '0) | (hi >= dvs_m);
    prep_nxt.dvs  = dvs_m;
    prep_nxt.rem  = {1'b0, hi};
    prep_nxt.dvd  = dvd_m[31:0];
    prep_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aux_r <= 1'b0;
      prep_r.vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        aux_r <= cfg_wdata;
      end
      prep_r.vld <= prep_nxt.vld;
    end
    prep_r.err  <= prep_nxt.err;
    prep_r.qneg <= prep_nxt.qneg;
    prep_r.rneg <= prep_nxt.rneg;
    prep_r.sz   <= prep_nxt.sz;
    prep_r.sgn  <= prep_nxt.sgn;
    prep_r.rem  <= prep_nxt.rem;
    prep_r.dvd  <= prep_nxt.dvd;
    prep_r.dvs  <= prep_nxt.dvs;
    prep_r.quo  <= prep_nxt.quo;
  end

  assign chain[0] = prep_r;
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    xdiv_cell u_cell (.clk(clk), .rst_n(rst_n), .d_in(chain[i]), .d_out(chain[i+1]));
  end

  cell_t       fin;
  logic [31:0] qm;
  logic [31:0] rm;
  logic [31:0] lim;
  logic [31:0] qv;
  logic [31:0] rv;
  logic [31:0] nmask;
  logic        ovf;
  logic        err;

  always_comb begin
    fin = chain[NCELL];
    qm = fin.quo;
    rm = fin.rem[31:0];
    unique case (size_t'(fin.sz))
      SZ_BYTE: begin
        nmask = 32'h0000_00ff;
        lim = 32'h0000_0080;
      end
      SZ_WORD: begin
        nmask = 32'h0000_ffff;
        lim = 32'h0000_8000;
      end
      SZ_DWORD, SZ_DWORD_ALT: begin
        nmask = 32'hffff_ffff;
        lim = 32'h8000_0000;
      end
    endcase
    ovf = ((qm & ~nmask) != '0);
    if (fin.sgn) begin
      ovf = ovf | (fin.qneg ? (qm > lim) : (qm >= lim));
    end
    err = fin.err | ovf;
    qv = fin.qneg ? 32'(-qm) : qm;
    rv = fin.rneg ? 32'(-rm) : rm;
  end

  logic        vld_r;
  logic [31:0] q_r;
  logic [31:0] r_r;
  logic        e_r;
  logic        a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= fin.vld;
    end
    q_r <= err ? '0 : (qv & nmask);
    r_r <= err ? '0 : (rv & nmask);
    e_r <= err;
    a_r <= ~err & aux_r;
  end

  assign out_strobe       = vld_r;
  assign out_quotient     = q_r;
  assign out_remainder    = r_r;
  assign out_divide_error = e_r;
  assign out_aux_toggle   = a_r;

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_divide_error |->
      out_quotient == '0 && out_remainder == '0 && !out_aux_toggle)
    else $error("error result not cleared");
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_aux_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_divide_error |-> out_aux_toggle == aux_r)
    else $error("aux toggle mismatch");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for x86_divide_unit (DIV/IDIV, byte/word/dword).
// Random and directed divides, predicted in-bench and compared as a whole result.
// Depends on xdiv_pkg and x86_divide_unit.
`timescale 1ns / 1ps
module tb_top;
  import xdiv_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [1:0]  size;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_op_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        divide_error;
    logic        aux_toggle;
  } div_res_t;

  localparam int LATENCY = 34;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [1:0]  in_size;
  logic [63:0] in_dividend;
  logic [31:0] in_divisor;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        out_strobe;
  logic [31:0] out_quotient;
  logic [31:0] out_remainder;
  logic        out_divide_error;
  logic        out_aux_toggle;

  div_op_t  pending_ops[$];
  div_res_t expected_results[$];
  bit       aux_enable;
  bit       driver_hold;
  bit       no_idle;
  int       mismatch_count;
  longint   cycle_count;

  x86_divide_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_size(in_size), .in_dividend(in_dividend),
    .in_divisor(in_divisor), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_quotient(out_quotient),
    .out_remainder(out_remainder), .out_divide_error(out_divide_error),
    .out_aux_toggle(out_aux_toggle)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic div_res_t divide_result(div_op_t op, bit aux_en);
    div_res_t r;
    int unsigned n;
    logic [63:0] nmask, dvd, dvs, ad, av, qm, rm, lim, q, rr;
    bit nd, nv, qneg, err;
    n = op.size[1] ? 32 : (op.size == SZ_WORD ? 16 : 8);
    nmask = (64'd1 << n) - 1;
    dvd = (n == 32) ? op.dividend : op.dividend & ((64'd1 << (2 * n)) - 1);
    dvs = {32'd0, op.divisor} & nmask;
    err = 1'b0;
    q = 0;
    rr = 0;
    if (dvs == 0) begin
      err = 1'b1;
    end else if (!op.mode) begin
      if ((dvd >> n) >= dvs) begin
        err = 1'b1;
      end else begin
        q = dvd / dvs;
        rr = dvd % dvs;
      end
    end else begin
      nd = dvd[2 * n - 1];
      nv = dvs[n - 1];
      ad = nd ? ((~dvd + 1) & ((n == 32) ? '1 : ((64'd1 << (2 * n)) - 1))) : dvd;
      av = nv ? ((~dvs + 1) & nmask) : dvs;
      qm = ad / av;
      rm = ad % av;
      lim = 64'd1 << (n - 1);
      qneg = nd != nv;
      if (qneg ? (qm > lim) : (qm >= lim)) begin
        err = 1'b1;
      end else begin
        q = qneg ? ~qm + 1 : qm;
        rr = nd ? ~rm + 1 : rm;
      end
    end
    r.quotient = err ? 32'd0 : q[31:0] & nmask[31:0];
    r.remainder = err ? 32'd0 : rr[31:0] & nmask[31:0];
    r.divide_error = err;
    r.aux_toggle = err ? 1'b0 : aux_en;
    return r;
  endfunction

  function automatic div_op_t random_divide();
    div_op_t op;
    int unsigned n;
    logic [63:0] dvs, q, rm;
    op.mode = 1'($urandom_range(0, 1));
    op.size = 2'($urandom_range(0, 3));
    op.dividend = {$urandom, $urandom};
    op.divisor = $urandom;
    n = op.size[1] ? 32 : (op.size == SZ_WORD ? 16 : 8);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // build a dividend that mostly fits: q*d + r
        dvs = {$urandom, $urandom} >> (64 - $urandom_range(1, n));
        if (dvs == 0) dvs = 1;
        q = {$urandom, $urandom} >> (64 - $urandom_range(1, n));
        rm = {$urandom, $urandom} % dvs;
        op.divisor = (op.divisor & ~((32'd1 << (n - 1)) << 1 | 32'd0)) ^ op.divisor
                     | dvs[31:0];
        op.divisor = op.divisor & ((n == 32) ? 32'hffffffff : (32'd1 << n) - 1)
                     | ({$urandom} & ~((n == 32) ? 32'hffffffff : (32'd1 << n) - 1));
        op.dividend = q * dvs + rm;
        if (op.mode && $urandom_range(0, 1)) op.dividend = -op.dividend;
        if (n < 32) begin
          op.dividend = (op.dividend & ((64'd1 << (2 * n)) - 1)) |
                        ({$urandom, $urandom} & ~((64'd1 << (2 * n)) - 1));
        end
      end
      5: op.divisor = op.divisor & ~((n == 32) ? 32'hffffffff : (32'd1 << n) - 1);
      6: op.divisor = op.divisor >> $urandom_range(0, 31);
      default: ;
    endcase
    return op;
  endfunction

  task automatic add_op(logic mode, logic [1:0] size, logic [63:0] dvd, logic [31:0] dvs);
    div_op_t op;
    op.mode = mode;
    op.size = size;
    op.dividend = dvd;
    op.divisor = dvs;
    pending_ops.push_back(op);
  endtask

  task automatic drain_and_set_aux(bit value);
    wait (pending_ops.size() == 0 && !start && expected_results.size() == 0);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    aux_enable = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_mode <= 1'b0;
      in_size <= SZ_BYTE;
      in_dividend <= '0;
      in_divisor <= '0;
    end else if (start && !busy) begin
      expected_results.push_back(divide_result({in_mode, in_size, in_dividend, in_divisor},
                                               aux_enable));
      if (pending_ops.size() > 0 && !driver_hold && (no_idle || $urandom_range(0, 99) >= 24))
      begin
        {in_mode, in_size, in_dividend, in_divisor} <= pending_ops.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_ops.size() > 0 && !driver_hold &&
                 (no_idle || $urandom_range(0, 99) >= 24)) begin
      {in_mode, in_size, in_dividend, in_divisor} <= pending_ops.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    div_res_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_quotient, out_remainder, out_divide_error, out_aux_toggle};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    aux_enable = 1'b0;
    driver_hold = 1'b0;
    no_idle = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_op(0, SZ_BYTE, 64'h0000, 32'h0);
    add_op(0, SZ_BYTE, 64'hffff, 32'hff);
    add_op(0, SZ_BYTE, 64'hfe01, 32'hff);
    add_op(1, SZ_BYTE, 64'hff80, 32'h01);
    add_op(1, SZ_BYTE, 64'h0080, 32'hff);
    add_op(1, SZ_BYTE, 64'h007f, 32'h01);
    add_op(1, SZ_BYTE, 64'hfff9, 32'h02);
    add_op(1, SZ_WORD, 64'hffff8000, 32'h0001);
    add_op(1, SZ_WORD, 64'h00008000, 32'hffff);
    add_op(0, SZ_WORD, 64'hfffeffff, 32'hffff);
    add_op(0, SZ_WORD, 64'hffffffff, 32'h0);
    add_op(1, SZ_DWORD, 64'hffffffff80000000, 32'h1);
    add_op(1, SZ_DWORD, 64'h0000000080000000, 32'hffffffff);
    add_op(1, SZ_DWORD, 64'h8000000000000000, 32'h80000000);
    add_op(0, SZ_DWORD, 64'hfffffffeffffffff, 32'hffffffff);
    add_op(0, SZ_DWORD, 64'hffffffffffffffff, 32'hffffffff);
    add_op(0, SZ_DWORD_ALT, 64'h0000000123456789, 32'h10);
    add_op(1, SZ_DWORD_ALT, 64'hfffffffffffffff9, 32'h2);
    add_op(0, SZ_BYTE, 64'hffffffffffff0064, 32'hffffff07);
    add_op(1, SZ_WORD, 64'hffffffff00000007, 32'hffff0000);
    drain_and_set_aux(1'b1);

    repeat (250) pending_ops.push_back(random_divide());
    drain_and_set_aux(1'b0);
    no_idle = 1'b1;
    repeat (250) pending_ops.push_back(random_divide());
    wait (pending_ops.size() == 0 && !start);
    no_idle = 1'b0;
    driver_hold = 1'b1;
    wait (expected_results.size() == 0);
    driver_hold = 1'b0;
    repeat (250) pending_ops.push_back(random_divide());
    drain_and_set_aux(1'b1);
    repeat (350) pending_ops.push_back(random_divide());

    wait (pending_ops.size() == 0 && !start && expected_results.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
